@@ design/sdop_pkg.sv @@
`timescale 1ns / 1ps

package sdop_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int MAX_RANK = 64;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ELEM_W = $clog2(MAX_RANK);
    localparam int VAL_W  = 32;
    localparam int PROD_W = 64;
    localparam int RANK_W = 7;
    localparam int CFG_W  = 64;

    localparam int LEFT_AW  = ROW_W + ELEM_W;
    localparam int RIGHT_AW = COL_W + ELEM_W;
    localparam int ACC_W    = 2 * VAL_W + ELEM_W + 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [1:0] {
        CMD_WRITE_LEFT  = 2'd0,
        CMD_WRITE_RIGHT = 2'd1,
        CMD_COMPUTE     = 2'd2
    } cmd_t;

    typedef enum logic {
        CFG_RANK    = 1'b0,
        CFG_CEILING = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } back_state_t;

    typedef struct packed {
        cmd_t              kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ELEM_W-1:0] elem;
        logic [VAL_W-1:0]  value;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

endpackage

@@ design/sdop_in_if.sv @@
`timescale 1ns / 1ps

interface sdop_in_if;
    import sdop_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         column_index;
    logic [ELEM_W-1:0]        element_index;
    logic signed [VAL_W-1:0]  factor_value;

    modport source (
        output valid, command, row_index, column_index, element_index, factor_value,
        input  ready
    );

    modport sink (
        input  valid, command, row_index, column_index, element_index, factor_value,
        output ready
    );
endinterface

@@ design/sdop_out_if.sv @@
`timescale 1ns / 1ps

interface sdop_out_if;
    import sdop_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] product;
    logic                     clamped;
    logic [ROW_W-1:0]         row_out;
    logic [COL_W-1:0]         column_out;

    modport source (
        output valid, product, clamped, row_out, column_out,
        input  ready
    );

    modport sink (
        input  valid, product, clamped, row_out, column_out,
        output ready
    );
endinterface

@@ design/sdop_front.sv @@
`timescale 1ns / 1ps

module sdop_front (
    input  logic                 clk,
    input  logic                 rst_n,
    sdop_in_if.sink              item,
    output sdop_pkg::queue_head_t head,
    input  logic                 pop
);
    import sdop_pkg::*;

    queue_entry_t       q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               known_cmd;
    logic               push;
    logic               do_pop;
    queue_entry_t       new_entry;

    assign item.ready = (count_reg != QCNT_W'(QDEPTH));

    always_comb
    begin
        case (item.command)
            CMD_WRITE_LEFT,
            CMD_WRITE_RIGHT,
            CMD_COMPUTE: known_cmd = 1'b1;
            default:     known_cmd = 1'b0;
        endcase
    end

    assign push   = item.valid && item.ready && known_cmd;
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        new_entry.kind  = cmd_t'(item.command);
        new_entry.row   = item.row_index;
        new_entry.col   = item.column_index;
        new_entry.elem  = item.element_index;
        new_entry.value = item.factor_value;
    end

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = q_mem_reg[rd_ptr_reg];

endmodule

@@ design/sdop_back.sv @@
`timescale 1ns / 1ps

module sdop_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sdop_pkg::queue_head_t          head,
    output logic                           pop,
    input  logic [sdop_pkg::RANK_W-1:0]    rank_in_use,
    input  logic [sdop_pkg::PROD_W-1:0]    ceiling,
    sdop_out_if.source                     result
);
    import sdop_pkg::*;

    logic [VAL_W-1:0] left_mem  [2**LEFT_AW];
    logic [VAL_W-1:0] right_mem [2**RIGHT_AW];

    back_state_t              state_reg;
    back_state_t              state_next;

    logic                     start;
    logic                     we_left;
    logic                     we_right;
    logic                     issue;
    logic                     finish;
    logic                     slot_free;
    logic [RANK_W-1:0]        rank_eff;

    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic [RANK_W-1:0]        n_reg;
    logic [RANK_W-1:0]        issue_cnt_reg;
    logic                     rd_vld_reg;
    logic                     mul_vld_reg;
    logic [VAL_W-1:0]         left_q_reg;
    logic [VAL_W-1:0]         right_q_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [LEFT_AW-1:0]       left_waddr;
    logic [RIGHT_AW-1:0]      right_waddr;
    logic [LEFT_AW-1:0]       left_raddr;
    logic [RIGHT_AW-1:0]      right_raddr;

    logic [ACC_W-PROD_W:0]    acc_top;
    logic                     acc_fits;
    logic [PROD_W-1:0]        acc_lo;
    logic [PROD_W-1:0]        res_value;
    logic                     res_flag;

    logic                     out_vld_reg;
    logic [PROD_W-1:0]        out_product_reg;
    logic                     out_clamped_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [COL_W-1:0]         out_col_reg;

    assign rank_eff  = (rank_in_use > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : rank_in_use;
    assign slot_free = !out_vld_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && (head.entry.kind == CMD_COMPUTE))
                begin
                    state_next = (rank_eff == '0) ? S_DRAIN : S_RUN;
                end
            end
            S_RUN:
            begin
                if (issue_cnt_reg + 1'b1 == n_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg && slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        start    = 1'b0;
        we_left  = 1'b0;
        we_right = 1'b0;
        issue    = 1'b0;
        finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.entry.kind)
                        CMD_WRITE_LEFT:  we_left  = 1'b1;
                        CMD_WRITE_RIGHT: we_right = 1'b1;
                        CMD_COMPUTE:     start    = 1'b1;
                        default:         ;
                    endcase
                end
            end
            S_RUN:   issue  = 1'b1;
            S_DRAIN: finish = !rd_vld_reg && !mul_vld_reg && slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
            if (finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign left_waddr  = {head.entry.row, head.entry.elem};
    assign right_waddr = {head.entry.col, head.entry.elem};
    assign left_raddr  = {row_reg, issue_cnt_reg[ELEM_W-1:0]};
    assign right_raddr = {col_reg, issue_cnt_reg[ELEM_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (we_left)
        begin
            left_mem[left_waddr] <= head.entry.value;
        end
        left_q_reg <= left_mem[left_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_right)
        begin
            right_mem[right_waddr] <= head.entry.value;
        end
        right_q_reg <= right_mem[right_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg       <= head.entry.row;
            col_reg       <= head.entry.col;
            n_reg         <= rank_eff;
            issue_cnt_reg <= '0;
        end
        else if (issue)
        begin
            issue_cnt_reg <= issue_cnt_reg + 1'b1;
        end

        if (rd_vld_reg)
        begin
            mul_reg <= $signed(left_q_reg) * $signed(right_q_reg);
        end

        if (start)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg};
        end
    end

    assign acc_top  = acc_reg[ACC_W-1:PROD_W-1];
    assign acc_fits = (acc_top == '0) || (acc_top == '1);
    assign acc_lo   = acc_reg[PROD_W-1:0];

    always_comb
    begin
        res_value = acc_lo;
        res_flag  = 1'b0;
        if (!acc_fits)
        begin
            if (acc_reg[ACC_W-1])
            begin
                res_value = {1'b1, {(PROD_W-1){1'b0}}};
            end
            else
            begin
                res_value = ceiling;
                res_flag  = 1'b1;
            end
        end
        else if ($signed(acc_lo) > $signed(ceiling))
        begin
            res_value = ceiling;
            res_flag  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_product_reg <= res_value;
            out_clamped_reg <= res_flag;
            out_row_reg     <= row_reg;
            out_col_reg     <= col_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.product    = out_product_reg;
    assign result.clamped    = out_clamped_reg;
    assign result.row_out    = out_row_reg;
    assign result.column_out = out_col_reg;

endmodule

@@ design/sampled_dense_outer_product.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake         payload
// item      in   valid / ready     command, row_index, column_index,
//                                  element_index, factor_value
// result    out  valid / ready     product, clamped, row_out, column_out
// cfg       in   cfg_we            cfg_index, cfg_data (no ready)
//
// A write command is done by the back end as it leaves the queue; a compute
// streams one left/right memory read pair per cycle, one per rank term, through
// a single multiply-accumulate unit. A four-entry queue lets the front take
// items while the back end works. The result register frees the back end as
// soon as the result moves on. Reset clears control state only; the factor
// memories hold undefined contents until written.

module sampled_dense_outer_product (
    input  logic                        clk,
    input  logic                        rst_n,
    sdop_in_if.sink                     item,
    sdop_out_if.source                  result,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [sdop_pkg::CFG_W-1:0]  cfg_data
);
    import sdop_pkg::*;

    queue_head_t        head;
    logic               pop;
    logic [RANK_W-1:0]  rank_reg;
    logic [PROD_W-1:0]  ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg    <= RANK_W'(MAX_RANK);
            ceiling_reg <= {1'b0, {(PROD_W-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RANK:    rank_reg    <= cfg_data[RANK_W-1:0];
                CFG_CEILING: ceiling_reg <= cfg_data[PROD_W-1:0];
                default:     ;
            endcase
        end
    end

    sdop_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .head  (head),
        .pop   (pop)
    );

    sdop_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .rank_in_use (rank_reg),
        .ceiling     (ceiling_reg),
        .result      (result)
    );

endmodule

@@ test/sampled_dense_outer_product_tb.sv @@
`timescale 1ns / 1ps

module sampled_dense_outer_product_tb;
    import sdop_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_ONE = 32'h0100_0000;

    localparam logic signed [PROD_W-1:0] PRODUCT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [PROD_W-1:0] PRODUCT_MIN = 64'sh8000_0000_0000_0000;

    localparam int TAIL_CYCLES = 2 * MAX_RANK + 16;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]        command;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ELEM_W-1:0] elem;
        logic [VAL_W-1:0]  value;
    } factor_op_t;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic              clamped;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } entry_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_we = 1'b0;
    cfg_index_t        cfg_sel = CFG_RANK;
    logic [CFG_W-1:0]  cfg_word = '0;

    factor_op_t op_now = '0;
    logic       op_valid = 1'b0;
    logic       op_taken = 1'b0;
    logic       take_ready = 1'b0;

    sdop_in_if  item_ch ();
    sdop_out_if result_ch ();

    assign item_ch.valid         = op_valid;
    assign item_ch.command       = op_now.command;
    assign item_ch.row_index     = op_now.row;
    assign item_ch.column_index  = op_now.col;
    assign item_ch.element_index = op_now.elem;
    assign item_ch.factor_value  = op_now.value;
    assign result_ch.ready       = take_ready;

    sampled_dense_outer_product i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_sel),
        .cfg_data  (cfg_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [VAL_W-1:0]         left_mem [2**LEFT_AW];
    logic [VAL_W-1:0]         right_mem [2**RIGHT_AW];
    logic [RANK_W-1:0]        cur_rank = RANK_W'(MAX_RANK);
    logic signed [PROD_W-1:0] cur_ceiling = PRODUCT_MAX;
    entry_result_t            entries_due [$];
    entry_result_t            want;
    int                       mismatches = 0;

    // stimulus state
    factor_op_t       pending_ops [$];
    bit               left_known [2**LEFT_AW];
    bit               right_known [2**RIGHT_AW];
    logic [ROW_W-1:0] row_pool [$];
    logic [COL_W-1:0] col_pool [$];
    int               ops_issued = 0;
    int               send_gap_pct = 0;
    int               stall_pct = 0;
    int               holds_requested = 0;
    int               holds_served = 0;
    int               hold_left = 0;
    int unsigned      cycles_run = 0;

    function automatic int effective_terms();
        return (cur_rank > RANK_W'(MAX_RANK)) ? MAX_RANK : int'(cur_rank);
    endfunction

    function automatic entry_result_t dot_entry(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        logic signed [ACC_W-1:0]  acc;
        logic signed [VAL_W-1:0]  a;
        logic signed [VAL_W-1:0]  b;
        logic signed [PROD_W-1:0] term;
        int                       terms;
        entry_result_t            res;
        terms = effective_terms();
        acc = '0;
        for (int j = 0; j < terms; j++)
        begin
            a = left_mem[{r, ELEM_W'(j)}];
            b = right_mem[{c, ELEM_W'(j)}];
            term = PROD_W'(a) * PROD_W'(b);
            acc = acc + ACC_W'(term);
        end
        res.row = r;
        res.col = c;
        if (acc > ACC_W'(cur_ceiling))
        begin
            res.product = cur_ceiling;
            res.clamped = 1'b1;
        end
        else if (acc < ACC_W'(PRODUCT_MIN))
        begin
            res.product = PRODUCT_MIN;
            res.clamped = 1'b0;
        end
        else
        begin
            res.product = acc[PROD_W-1:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    task automatic take_op(factor_op_t op);
        case (op.command)
            CMD_WRITE_LEFT:  left_mem[{op.row, op.elem}] = op.value;
            CMD_WRITE_RIGHT: right_mem[{op.col, op.elem}] = op.value;
            CMD_COMPUTE:     entries_due.push_back(dot_entry(op.row, op.col));
            default: ;
        endcase
    endtask

    // check results, then predict from the transfer on the input side
    always @(posedge clk)
    begin
        op_taken <= rst_n && op_valid && item_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (entries_due.size() == 0)
            begin
                $error("result with no compute pending: row %0d column %0d",
                       result_ch.row_out, result_ch.column_out);
                mismatches++;
            end
            else
            begin
                want = entries_due.pop_front();
                if (result_ch.product !== want.product)
                begin
                    $error("product: expected %h, got %h", want.product, result_ch.product);
                    mismatches++;
                end
                if (result_ch.clamped !== want.clamped)
                begin
                    $error("clamped: expected %b, got %b", want.clamped, result_ch.clamped);
                    mismatches++;
                end
                if (result_ch.row_out !== want.row)
                begin
                    $error("row_out: expected %0d, got %0d", want.row, result_ch.row_out);
                    mismatches++;
                end
                if (result_ch.column_out !== want.col)
                begin
                    $error("column_out: expected %0d, got %0d", want.col, result_ch.column_out);
                    mismatches++;
                end
            end
        end
        if (rst_n && op_valid && item_ch.ready)
            take_op(op_now);
    end

    always @(negedge clk)
    begin
        if (rst_n && (!op_valid || op_taken))
        begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                op_now   <= pending_ops.pop_front();
                op_valid <= 1'b1;
            end
            else
                op_valid <= 1'b0;
        end
    end

    // hold off the result side for a long stretch when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left  <= hold_left - 1;
            take_ready <= 1'b0;
        end
        else if (rst_n && holds_served < holds_requested)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            take_ready   <= 1'b0;
        end
        else
            take_ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_sel  <= idx;
        cfg_word <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RANK)
            cur_rank = data[RANK_W-1:0];
        else
            cur_ceiling = data;
    endtask

    function automatic logic [CFG_W-1:0] rank_word(int n);
        logic [CFG_W-1:0] w;
        w = {$urandom, $urandom};
        w[RANK_W-1:0] = RANK_W'(n);
        return w;
    endfunction

    function automatic logic [VAL_W-1:0] factor_pick();
        logic [VAL_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = {{7{v[25]}}, v[24:0]};
            8:             v = VAL_MAX;
            9:             v = VAL_MIN;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [ROW_W-1:0] row_pick();
        return row_pool[$urandom_range(0, row_pool.size() - 1)];
    endfunction

    function automatic logic [COL_W-1:0] col_pick();
        return col_pool[$urandom_range(0, col_pool.size() - 1)];
    endfunction

    task automatic push_op(logic [1:0] command, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [ELEM_W-1:0] elem, logic [VAL_W-1:0] value);
        pending_ops.push_back('{command, row, col, elem, value});
        if (command == CMD_WRITE_LEFT)
            left_known[{row, elem}] = 1'b1;
        if (command == CMD_WRITE_RIGHT)
            right_known[{col, elem}] = 1'b1;
        if (command != CMD_UNUSED)
            ops_issued++;
    endtask

    // fill any unwritten elements the compute will read, then issue it
    task automatic push_compute(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        int terms;
        terms = effective_terms();
        for (int j = 0; j < terms; j++)
        begin
            if (!left_known[{r, ELEM_W'(j)}])
                push_op(CMD_WRITE_LEFT, r, COL_W'($urandom), ELEM_W'(j), factor_pick());
            if (!right_known[{c, ELEM_W'(j)}])
                push_op(CMD_WRITE_RIGHT, ROW_W'($urandom), c, ELEM_W'(j), factor_pick());
        end
        push_op(CMD_COMPUTE, r, c, ELEM_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic random_phase(int count);
        int target;
        int pick;
        target = ops_issued + count;
        while (ops_issued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                push_op(CMD_UNUSED, ROW_W'($urandom), COL_W'($urandom),
                        ELEM_W'($urandom), VAL_W'($urandom));
            else if (pick < 22)
                push_op(CMD_WRITE_LEFT,
                        ($urandom_range(0, 3) == 0) ? ROW_W'($urandom) : row_pick(),
                        COL_W'($urandom), ELEM_W'($urandom), factor_pick());
            else if (pick < 40)
                push_op(CMD_WRITE_RIGHT, ROW_W'($urandom),
                        ($urandom_range(0, 3) == 0) ? COL_W'($urandom) : col_pick(),
                        ELEM_W'($urandom), factor_pick());
            else if (effective_terms() == 0)
                push_compute(ROW_W'($urandom), COL_W'($urandom));
            else
                push_compute(row_pick(), col_pick());
        end
    endtask

    task automatic drain_block();
        while (pending_ops.size() != 0 || op_valid || entries_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_RANK, rank_word(4));
        write_reg(CFG_CEILING, PRODUCT_MAX);
        for (int j = 0; j < 4; j++)
            push_op(CMD_WRITE_LEFT, '0, '0, ELEM_W'(j), VAL_MIN);
        for (int j = 0; j < 4; j++)
            push_op(CMD_WRITE_RIGHT, '0, '0, ELEM_W'(j), VAL_MIN);
        push_op(CMD_COMPUTE, '0, '0, '0, '0);
        for (int j = 0; j < 4; j++)
            push_op(CMD_WRITE_RIGHT, '1, '1, ELEM_W'(j), VAL_MAX);
        push_op(CMD_COMPUTE, '0, '1, '1, '1);
        for (int j = 0; j < 4; j++)
            push_op(CMD_WRITE_LEFT, '1, '1, ELEM_W'(j), VAL_ONE);
        push_op(CMD_COMPUTE, '1, '1, '0, '0);
        push_op(CMD_COMPUTE, '1, '0, '0, '1);
        push_op(CMD_UNUSED, '1, '1, '1, '1);
        push_op(CMD_WRITE_LEFT, '1, '0, '1, '0);
        push_op(CMD_WRITE_RIGHT, '0, '0, '1, '1);
        push_op(CMD_COMPUTE, '0, '0, '1, '1);
        drain_block();

        row_pool.push_back('0);
        row_pool.push_back(ROW_W'(MAX_ROWS - 1));
        col_pool.push_back('0);
        col_pool.push_back(COL_W'(MAX_COLS - 1));
        repeat (2)
        begin
            row_pool.push_back(ROW_W'($urandom));
            col_pool.push_back(COL_W'($urandom));
        end

        // fill the block while results are held back
        write_reg(CFG_RANK, rank_word(1));
        write_reg(CFG_CEILING, '0);
        holds_requested++;
        random_phase(150);
        drain_block();

        write_reg(CFG_RANK, rank_word(0));
        write_reg(CFG_CEILING, PRODUCT_MIN);
        send_gap_pct = 78;
        random_phase(100);
        drain_block();

        write_reg(CFG_RANK, rank_word($urandom_range(2, 16)));
        write_reg(CFG_CEILING, $signed({$urandom, $urandom}) >>> 14);
        send_gap_pct = 0;
        stall_pct = 78;
        random_phase(150);
        drain_block();

        write_reg(CFG_RANK, rank_word(MAX_RANK));
        write_reg(CFG_CEILING, PRODUCT_MAX);
        send_gap_pct = 10;
        stall_pct = 10;
        random_phase(250);
        drain_block();

        write_reg(CFG_RANK, rank_word(127));
        write_reg(CFG_CEILING, {$urandom, $urandom});
        send_gap_pct = 0;
        stall_pct = 0;
        random_phase(180);
        drain_block();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
